[rtl/lbpc_pkg.sv]
// Shared types and constants for the LED blink persistence classifier.
`default_nettype none

package lbpc_pkg;

  // Default samples per judging window.
  localparam int unsigned WINDOW_SIZE_DEF = 64;

  // Result queue depth; must hold at least two beats.
  localparam int unsigned RES_DEPTH = 4;

  localparam int unsigned LED_W   = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned CFG_W   = 8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LED_INDEX    = 1'b0,
    REG_PERIOD_LIMIT = 1'b1
  } cfg_reg_t;

  // Edge tracker phase.
  typedef enum logic [2:0] {
    EDGE_NONE  = 3'b001,
    EDGE_FIRST = 3'b010,
    EDGE_DONE  = 3'b100
  } edge_phase_t;

  // One result beat.
  typedef struct packed {
    logic [LED_W-1:0] led_number;
    logic             led_on;
    logic             last_of_run;
  } beat_t;

  // Beats produced by one accepted sample, in order.
  typedef struct packed {
    logic [1:0] cnt;
    beat_t      b0;
    beat_t      b1;
  } push_t;

endpackage : lbpc_pkg

`default_nettype wire

[rtl/lbpc_core.sv]
// Window state, edge tracker and judgment for one sample per cycle while acc is high.
`default_nettype none

module lbpc_core #(
  parameter int unsigned WINDOW_SIZE = lbpc_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire logic                         level,
  input  wire logic [lbpc_pkg::LED_W-1:0]   led_index,
  input  wire logic [lbpc_pkg::LIMIT_W-1:0] period_limit,
  output lbpc_pkg::push_t                   push
);
  import lbpc_pkg::*;

  localparam int unsigned POS_W    = $clog2(WINDOW_SIZE);
  localparam int unsigned CNT_W    = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned CMP_W    = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
  // count*20 < W  <=>  count <= (W-1)/20
  localparam int unsigned LOW_MAX  = (WINDOW_SIZE - 1) / 20;
  // count*20 > 19W  <=>  count > 19W/20
  localparam int unsigned HIGH_MAX = (19 * WINDOW_SIZE) / 20;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] hc_r, hc_nxt;
  logic             first_lvl_r, first_lvl_nxt;
  logic             prev_lvl_r, prev_lvl_nxt;
  edge_phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] first_pos_r, first_pos_nxt;
  logic [POS_W-1:0] period_r, period_nxt;
  logic             slow_r, slow_nxt;

  logic  win_end;
  logic  judge_emit;
  logic  judge_on;
  beat_t echo_b, judge_b;

  always_comb begin
    first_lvl_nxt = first_lvl_r;
    phase_nxt     = phase_r;
    first_pos_nxt = first_pos_r;
    period_nxt    = period_r;
    hc_nxt        = hc_r + CNT_W'(level);
    if (pos_r == '0) begin
      // Open a new window.
      first_lvl_nxt = level;
      phase_nxt     = EDGE_NONE;
      first_pos_nxt = '0;
      period_nxt    = '0;
      hc_nxt        = CNT_W'(level);
    end else if (level != prev_lvl_r) begin
      if (phase_r == EDGE_NONE) begin
        phase_nxt     = EDGE_FIRST;
        first_pos_nxt = pos_r;
      end else if (phase_r == EDGE_FIRST && level != first_lvl_r) begin
        period_nxt = pos_r - first_pos_r;
        phase_nxt  = EDGE_DONE;
      end
    end
    prev_lvl_nxt = level;

    win_end = (pos_r == POS_W'(WINDOW_SIZE - 1));
    pos_nxt = win_end ? '0 : pos_r + 1'b1;

    judge_emit = 1'b1;
    judge_on   = 1'b1;
    if (hc_nxt <= CNT_W'(LOW_MAX)) begin
      judge_on = 1'b0;
    end else if (hc_nxt > CNT_W'(HIGH_MAX)) begin
      judge_on = 1'b1;
    end else if (phase_nxt == EDGE_DONE &&
                 CMP_W'(period_nxt) < CMP_W'(period_limit)) begin
      judge_on = 1'b1;
    end else begin
      judge_emit = 1'b0;
    end
    slow_nxt = win_end ? !judge_emit : slow_r;

    echo_b.led_number  = led_index;
    echo_b.led_on      = level;
    echo_b.last_of_run = !(win_end && judge_emit);
    judge_b.led_number  = led_index;
    judge_b.led_on      = judge_on;
    judge_b.last_of_run = 1'b1;

    push.cnt = '0;
    push.b0  = echo_b;
    push.b1  = judge_b;
    if (acc) begin
      if (slow_r) begin
        push.cnt = (win_end && judge_emit) ? 2'd2 : 2'd1;
      end else if (win_end && judge_emit) begin
        push.cnt = 2'd1;
        push.b0  = judge_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hc_r        <= '0;
      first_lvl_r <= 1'b0;
      prev_lvl_r  <= 1'b0;
      phase_r     <= EDGE_NONE;
      first_pos_r <= '0;
      period_r    <= '0;
      slow_r      <= 1'b1;
    end else if (acc) begin
      pos_r       <= pos_nxt;
      hc_r        <= hc_nxt;
      first_lvl_r <= first_lvl_nxt;
      prev_lvl_r  <= prev_lvl_nxt;
      phase_r     <= phase_nxt;
      first_pos_r <= first_pos_nxt;
      period_r    <= period_nxt;
      slow_r      <= slow_nxt;
    end
  end

  // High count can never outrun the samples seen in this window.
  a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '0 |-> hc_r <= CNT_W'(pos_r))
    else $error("high count exceeds window position");

  // Outside slow mode, a mid-window sample produces no beat.
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !slow_r && !win_end |-> push.cnt == 2'd0)
    else $error("beat produced outside slow mode mid-window");

endmodule : lbpc_core

`default_nettype wire

[rtl/lbpc_resq.sv]
// Small result queue taking up to two beats per cycle, draining one unless out_stall is high.
`default_nettype none

module lbpc_resq (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire lbpc_pkg::push_t push,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_stall,
  output lbpc_pkg::beat_t out_beat
);
  import lbpc_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  beat_t            mem_r [RES_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [PTR_W-1:0] wptr_p1;

  always_comb begin
    pop       = (cnt_r != '0) && !out_stall;
    wptr_p1   = wptr_r + 1'b1;
    wptr_nxt  = wptr_r + PTR_W'(push.cnt);
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt   = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
    // Hold input while fewer than two slots are free.
    room      = (cnt_r <= CNT_W'(RES_DEPTH - 2));
    out_valid = (cnt_r != '0);
    out_beat  = mem_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.b0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_p1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("push into full result queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_DEPTH))
    else $error("result queue count out of range");

endmodule : lbpc_resq

`default_nettype wire

[rtl/led_blink_persistence_classifier_unit.sv]
// Top level of the LED blink persistence classifier.
//
// Input channel: one pin sample per beat (in_level), taken when in_valid
// is high and in_stall is low. Result channel: LED events (out_led_number,
// out_led_on, out_last_of_run), taken when out_valid is high and out_stall
// is low. Each sample yields zero, one or two beats; out_last_of_run marks
// the final beat caused by a sample.
// In slow mode every sample is echoed as an on/off event. The last sample
// of each WINDOW_SIZE-sample window is judged by duty and blink period,
// and may add a judgment beat, after the echo in slow mode.
// Throughput: one sample per cycle while in_stall is low. A beat is
// queued on accept and offered after earlier beats. All window state
// updates in the accept cycle; results pass through a four-beat queue,
// so the receiver may stall while samples keep flowing until the queue is
// nearly full, at which point in_stall rises. Stalled beats hold steady.
// Configuration: cfg_we with cfg_index and cfg_wdata writes led_index (0)
// or period_limit (1, low 7 bits); write only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, clears the window and
// edge tracker, sets slow mode, led_index 0 and period_limit 8.
`default_nettype none

module led_blink_persistence_classifier_unit #(
  parameter int unsigned WINDOW_SIZE = lbpc_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_level,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [lbpc_pkg::LED_W-1:0]      out_led_number,
  output logic                            out_led_on,
  output logic                            out_last_of_run,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [lbpc_pkg::CFG_W-1:0] cfg_wdata
);
  import lbpc_pkg::*;

  logic [LED_W-1:0]   led_index_r;
  logic [LIMIT_W-1:0] period_limit_r;
  logic               room;
  logic               in_acc;
  push_t              push;
  beat_t              head;

  // Register writes: keep only the low bits of each register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_index_r    <= '0;
      period_limit_r <= LIMIT_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LED_INDEX:    led_index_r    <= cfg_wdata[LED_W-1:0];
        REG_PERIOD_LIMIT: period_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Stall the source when the queue cannot take a two-beat sample.
  assign in_stall = !room;
  assign in_acc   = in_valid && room;

  lbpc_core #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .level        (in_level),
    .led_index    (led_index_r),
    .period_limit (period_limit_r),
    .push         (push)
  );

  lbpc_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (head)
  );

  assign out_led_number  = head.led_number;
  assign out_led_on      = head.led_on;
  assign out_last_of_run = head.last_of_run;

  // A beat offered and stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

endmodule : led_blink_persistence_classifier_unit

`default_nettype wire
